@@ hw/rtl/dmmn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmn_pkg
// Shared constants and types of the depth min-max normalizer.
// ----------------------------------------------------------------------------
package dmmn_pkg;

   localparam int DEPTH_BITS_DEF = 32;
   localparam int GRAY_BITS_DEF  = 16;

   // port field widths
   localparam int DEPTH_W     = 32;
   localparam int GRAY_W      = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 24;

   localparam int QUEUE_DEPTH = 4;

   // request kinds carried on tuser
   localparam logic KIND_GATHER    = 1'b0;
   localparam logic KIND_NORMALIZE = 1'b1;

   typedef struct packed {
      logic last;
      logic zero_span;
      logic clipped;
      logic divide;
      logic saturate;
   } dmmn_flags_type;

   localparam int FLAGS_W = $bits(dmmn_flags_type);

endpackage

@@ hw/rtl/dmmn_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmn_front
// Accepts requests, tracks the running range in the gather pass and
// classifies normalize requests against the frozen range.
// ----------------------------------------------------------------------------
module dmmn_front
   import dmmn_pkg::*;
#(
   parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_kind,
   input  logic [DEPTH_W-1:0]    in_depth,
   input  logic                  in_no_hit,
   input  logic                  in_last,
   output logic                  push,
   input  logic                  queue_full,
   output dmmn_flags_type        push_flags,
   output logic [DEPTH_BITS-1:0] push_num,
   output logic [DEPTH_BITS-1:0] push_den
);

   logic [DEPTH_BITS-1:0] rmin_ff, rmin_in;
   logic [DEPTH_BITS-1:0] rmax_ff, rmax_in;
   logic                  hit_ff, hit_in;
   logic [DEPTH_BITS-1:0] fmin_ff, fmin_in;
   logic [DEPTH_BITS-1:0] fmax_ff, fmax_in;
   logic [DEPTH_BITS-1:0] span_ff, span_in;
   logic                  span_zero_ff, span_zero_in;
   logic                  pend_ff, pend_in;

   logic [DEPTH_BITS-1:0] depth;
   logic [DEPTH_BITS-1:0] nmin, nmax;
   logic                  accept, gather, hit;
   logic                  below, above, at_max;

   assign depth    = DEPTH_BITS'(in_depth);
   assign in_ready = !pend_ff && (in_kind == KIND_GATHER || !queue_full);
   assign accept   = in_valid && in_ready;
   assign gather   = (in_kind == KIND_GATHER);
   assign hit      = !in_no_hit;

   assign nmin = (depth < rmin_ff) ? depth : rmin_ff;
   assign nmax = (depth > rmax_ff) ? depth : rmax_ff;

   assign below  = depth < fmin_ff;
   assign above  = depth > fmax_ff;
   assign at_max = depth == fmax_ff;

   always_comb begin
      rmin_in      = rmin_ff;
      rmax_in      = rmax_ff;
      hit_in       = hit_ff;
      fmin_in      = fmin_ff;
      fmax_in      = fmax_ff;
      span_in      = span_ff;
      span_zero_in = span_zero_ff;
      pend_in      = 1'b0;
      if (pend_ff) begin
         span_in      = fmax_ff - fmin_ff;
         span_zero_in = (fmax_ff == fmin_ff);
      end
      if (accept && gather) begin
         if (hit) begin
            rmin_in = nmin;
            rmax_in = nmax;
            hit_in  = 1'b1;
         end
         if (in_last) begin
            if (hit) begin
               fmin_in = nmin;
               fmax_in = nmax;
            end else if (hit_ff) begin
               fmin_in = rmin_ff;
               fmax_in = rmax_ff;
            end else begin
               fmin_in = '0;
               fmax_in = '0;
            end
            rmin_in = '1;
            rmax_in = '0;
            hit_in  = 1'b0;
            pend_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rmin_ff      <= '1;
         rmax_ff      <= '0;
         hit_ff       <= 1'b0;
         fmin_ff      <= '0;
         fmax_ff      <= '0;
         span_ff      <= '0;
         span_zero_ff <= 1'b1;
         pend_ff      <= 1'b0;
      end else begin
         rmin_ff      <= rmin_in;
         rmax_ff      <= rmax_in;
         hit_ff       <= hit_in;
         fmin_ff      <= fmin_in;
         fmax_ff      <= fmax_in;
         span_ff      <= span_in;
         span_zero_ff <= span_zero_in;
         pend_ff      <= pend_in;
      end
   end

   assign push                 = accept && !gather;
   assign push_flags.last      = in_last;
   assign push_flags.zero_span = hit && span_zero_ff;
   assign push_flags.clipped   = hit && !span_zero_ff && (below || above);
   assign push_flags.divide    = hit && !span_zero_ff && !below && !above && !at_max;
   assign push_flags.saturate  = hit && !span_zero_ff && !below && (above || at_max);
   assign push_num             = depth - fmin_ff;
   assign push_den             = span_ff;

endmodule

@@ hw/rtl/dmmn_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmn_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module dmmn_queue
   import dmmn_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0]   count_ff;
   logic             do_push, do_pop;

   assign full      = (count_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ hw/rtl/dmmn_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmn_back
// Restoring fraction divider, one quotient bit a cycle, and the response
// output register.
// ----------------------------------------------------------------------------
module dmmn_back
   import dmmn_pkg::*;
#(
   parameter int DEPTH_BITS = DEPTH_BITS_DEF,
   parameter int GRAY_BITS  = GRAY_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  dmmn_flags_type        q_flags,
   input  logic [DEPTH_BITS-1:0] q_num,
   input  logic [DEPTH_BITS-1:0] q_den,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [GRAY_W-1:0]     out_gray,
   output logic                  out_last,
   output logic                  out_zero_span,
   output logic                  out_clipped
);

   localparam int CNT_W = $clog2(GRAY_BITS);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_type;

   state_type             state_ff, state_in;
   logic [DEPTH_BITS-1:0] rem_ff, rem_in;
   logic [DEPTH_BITS-1:0] den_ff, den_in;
   logic [GRAY_BITS-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   dmmn_flags_type        flags_ff, flags_in;
   logic                  valid_ff, valid_in;
   logic [GRAY_W-1:0]     gray_ff, gray_in;
   logic                  last_ff, last_in;
   logic                  zspan_ff, zspan_in;
   logic                  clip_ff, clip_in;

   logic [DEPTH_BITS:0]   rem2;
   logic                  take;
   logic                  out_free;

   assign rem2     = {rem_ff, 1'b0};
   assign take     = rem2 >= {1'b0, den_ff};
   assign out_free = !valid_ff || out_ready;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      flags_in = flags_ff;
      valid_in = valid_ff && !out_ready;
      gray_in  = gray_ff;
      last_in  = last_ff;
      zspan_in = zspan_ff;
      clip_in  = clip_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               flags_in = q_flags;
               rem_in   = q_num;
               den_in   = q_den;
               cnt_in   = CNT_W'(GRAY_BITS - 1);
               quo_in   = q_flags.saturate ? '1 : '0;
               state_in = q_flags.divide ? S_DIV : S_DONE;
            end
         end
         S_DIV: begin
            quo_in = {quo_ff[GRAY_BITS-2:0], take};
            rem_in = take ? DEPTH_BITS'(rem2 - {1'b0, den_ff}) : rem2[DEPTH_BITS-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               valid_in = 1'b1;
               gray_in  = GRAY_W'(quo_ff);
               last_in  = flags_ff.last;
               zspan_in = flags_ff.zero_span;
               clip_in  = flags_ff.clipped;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      flags_ff <= flags_in;
      gray_ff  <= gray_in;
      last_ff  <= last_in;
      zspan_ff <= zspan_in;
      clip_ff  <= clip_in;
   end

   assign out_valid     = valid_ff;
   assign out_gray      = gray_ff;
   assign out_last      = last_ff;
   assign out_zero_span = zspan_ff;
   assign out_clipped   = clip_ff;

endmodule

@@ hw/rtl/depth_min_max_normalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_min_max_normalizer
// Two-pass min-max normalization of a streamed depth image to gray levels.
//
// req channel: tuser is the pass (0 gather, 1 normalize), tlast marks the
// final pixel of a pass, tdata carries depth and the no-hit flag.
// rsp channel: one response per normalize request, none per gather request;
// tlast echoes the request's tlast.
// Gather requests are taken one per cycle, but the request closing a gather
// pass drops req_tready in the cycle after it while the span register loads.
// Normalize requests go through a four-entry queue to a restoring divider
// that yields one quotient bit a cycle and takes one pixel at a time; no-hit,
// clipped or zero-span pixels skip the division.
// Reset clears the running range, sets the frozen range to zero (so hit pixels
// give gray 0 with zero_span until a gather pass ends) and empties the queue.
// When the receiver stalls, the response holds in the output register, the
// divider and queue fill, and then req_tready drops for normalize requests.
// ----------------------------------------------------------------------------
module depth_min_max_normalizer
   import dmmn_pkg::*;
#(
   parameter int DEPTH_BITS = DEPTH_BITS_DEF,
   parameter int GRAY_BITS  = GRAY_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // depth[31:0], no_hit[32]
   input  logic                  req_tuser,   // kind
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // gray[15:0], zero_span[16], clipped[17]
   output logic                  rsp_tlast
);

   localparam int ENTRY_W = FLAGS_W + 2 * DEPTH_BITS;

   logic                  push, full, pop, pop_valid;
   dmmn_flags_type        push_flags, pop_flags;
   logic [DEPTH_BITS-1:0] push_num, push_den, pop_num, pop_den;
   logic [ENTRY_W-1:0]    push_data, pop_data;
   logic [GRAY_W-1:0]     gray;
   logic                  zero_span, clipped;

   dmmn_front #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_kind    (req_tuser),
      .in_depth   (req_tdata[DEPTH_W-1:0]),
      .in_no_hit  (req_tdata[DEPTH_W]),
      .in_last    (req_tlast),
      .push       (push),
      .queue_full (full),
      .push_flags (push_flags),
      .push_num   (push_num),
      .push_den   (push_den)
   );

   assign push_data = {push_flags, push_num, push_den};

   dmmn_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   assign pop_flags = pop_data[ENTRY_W-1 -: FLAGS_W];
   assign pop_num   = pop_data[2*DEPTH_BITS-1 -: DEPTH_BITS];
   assign pop_den   = pop_data[DEPTH_BITS-1:0];

   dmmn_back #(
      .DEPTH_BITS (DEPTH_BITS),
      .GRAY_BITS  (GRAY_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (pop_valid),
      .q_pop         (pop),
      .q_flags       (pop_flags),
      .q_num         (pop_num),
      .q_den         (pop_den),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_gray      (gray),
      .out_last      (rsp_tlast),
      .out_zero_span (zero_span),
      .out_clipped   (clipped)
   );

   assign rsp_tdata = {(RSP_DATA_W - GRAY_W - 2)'(0), clipped, zero_span, gray};

endmodule

@@ tb/dmmn_gray_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmn_gray_checker
// Watches both streams of the depth min-max normalizer. Keeps its own running
// and frozen range and works out the gray response of every accepted
// normalize request. Each accepted response is compared with the oldest one
// still outstanding. Failures and the outstanding count go to the top.
// ----------------------------------------------------------------------------
module dmmn_gray_checker
   import dmmn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // depth[31:0], no_hit[32]
   input  logic                  req_tuser,   // kind
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // gray[15:0], zero_span[16], clipped[17]
   input  logic                  rsp_tlast,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic              last;
      logic              zero_span;
      logic              clipped;
   } gray_rsp_type;

   gray_rsp_type gray_expect_q[$];

   logic [DEPTH_W-1:0] run_min;
   logic [DEPTH_W-1:0] run_max;
   logic [DEPTH_W-1:0] frz_min;
   logic [DEPTH_W-1:0] frz_span;
   logic               any_hit;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic predict_request();
      logic [DEPTH_W-1:0]      depth;
      logic                    no_hit;
      logic [DEPTH_W-1:0]      diff;
      logic [DEPTH_W+GRAY_W-1:0] quot;
      gray_rsp_type            rsp;
      depth  = req_tdata[DEPTH_W-1:0];
      no_hit = req_tdata[DEPTH_W];
      if (req_tuser == KIND_GATHER) begin
         if (!no_hit) begin
            if (depth < run_min) run_min = depth;
            if (depth > run_max) run_max = depth;
            any_hit = 1'b1;
         end
         if (req_tlast) begin
            if (any_hit) begin
               frz_min  = run_min;
               frz_span = run_max - run_min;
            end else begin
               frz_min  = '0;
               frz_span = '0;
            end
            run_min = '1;
            run_max = '0;
            any_hit = 1'b0;
         end
      end else begin
         rsp = '0;
         rsp.last = req_tlast;
         if (!no_hit) begin
            if (frz_span == 0) begin
               rsp.zero_span = 1'b1;
            end else if (depth < frz_min) begin
               rsp.clipped = 1'b1;
            end else begin
               diff = depth - frz_min;
               if (diff > frz_span) begin
                  rsp.gray    = '1;
                  rsp.clipped = 1'b1;
               end else begin
                  quot = {diff, {GRAY_W{1'b0}}} / {{GRAY_W{1'b0}}, frz_span};
                  rsp.gray = (quot > {GRAY_W{1'b1}}) ? {GRAY_W{1'b1}} : quot[GRAY_W-1:0];
               end
            end
         end
         gray_expect_q.push_back(rsp);
      end
   endtask

   task automatic check_response();
      gray_rsp_type want;
      if (gray_expect_q.size() == 0) begin
         report_mismatch("response with none outstanding", 32'(rsp_tdata), 32'(0));
      end else begin
         want = gray_expect_q.pop_front();
         if (rsp_tdata[GRAY_W-1:0] !== want.gray)
            report_mismatch("gray", 32'(rsp_tdata[GRAY_W-1:0]), 32'(want.gray));
         if (rsp_tlast !== want.last)
            report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
         if (rsp_tdata[GRAY_W] !== want.zero_span)
            report_mismatch("zero_span", 32'(rsp_tdata[GRAY_W]), 32'(want.zero_span));
         if (rsp_tdata[GRAY_W+1] !== want.clipped)
            report_mismatch("clipped", 32'(rsp_tdata[GRAY_W+1]), 32'(want.clipped));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         run_min  = '1;
         run_max  = '0;
         frz_min  = '0;
         frz_span = '0;
         any_hit  = 1'b0;
         gray_expect_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         if (req_tvalid && req_tready) predict_request();
      end
      pending_count <= gray_expect_q.size();
   end

endmodule

@@ tb/depth_min_max_normalizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_min_max_normalizer_tb
// Drives gather and normalize passes into the normalizer: a directed set of
// range corners, then random frames with some noise, under three idle
// patterns on request and response side. A checker beside the block predicts
// and compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module depth_min_max_normalizer_tb;
   import dmmn_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 510;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // depth[31:0], no_hit[32]
   logic                  req_tuser  = 1'b0; // kind
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // gray[15:0], zero_span[16], clipped[17]
   logic                  rsp_tlast;

   int fail_count;
   int pending_count;
   int cycle_count    = 0;
   int sent_count     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   depth_min_max_normalizer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   dmmn_gray_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_tready  <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // a closing gather request waits until the queued normalize requests are out
   task automatic send_req(input logic kind, input logic [DEPTH_W-1:0] depth,
                           input logic no_hit, input logic last);
      if (kind == KIND_GATHER && last) wait_for_drain();
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tlast  <= last;
      req_tdata  <= {{(REQ_DATA_W-DEPTH_W-1){1'b0}}, no_hit, depth};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic run_random_frame();
      int                 mode;
      int                 n_gather;
      int                 n_norm;
      int                 pick;
      logic [DEPTH_W-1:0] base;
      logic [DEPTH_W-1:0] width;
      logic [DEPTH_W-1:0] value;
      logic [DEPTH_W-1:0] lo;
      logic [DEPTH_W-1:0] hi;
      logic               hit;
      logic               seen;
      mode     = $urandom_range(4);
      n_gather = $urandom_range(12, 1);
      n_norm   = $urandom_range(16, 1);
      base     = $urandom;
      width    = $urandom_range(255, 1);
      seen     = 1'b0;
      lo       = '0;
      hi       = '0;
      for (int i = 0; i < n_gather; i++) begin
         case (mode)
            0: value = $urandom;
            1: value = base + $urandom_range(width);
            2: begin
               pick  = $urandom_range(2);
               value = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
            end
            default: value = base;
         endcase
         hit = (mode != 4) && ($urandom_range(99) >= 15);
         if (hit) begin
            if (!seen || value < lo) lo = value;
            if (!seen || value > hi) hi = value;
            seen = 1'b1;
         end
         send_req(KIND_GATHER, value, !hit, i == n_gather - 1);
      end
      for (int i = 0; i < n_norm; i++) begin
         pick = $urandom_range(99);
         if (pick < 70)
            value = lo + $urandom_range(hi - lo);
         else if (pick < 80 && lo != 0)
            value = $urandom_range(lo - 1);
         else if (pick < 90 && hi != '1)
            value = hi + 1 + $urandom_range('1 - hi - 1);
         else if (pick < 95)
            value = $urandom_range(1) ? lo : hi;
         else
            value = $urandom;
         send_req(KIND_NORMALIZE, value, $urandom_range(99) < 10,
                  (i == n_norm - 1) || ($urandom_range(99) < 5));
      end
      if ($urandom_range(99) < 8) begin
         n_norm = $urandom_range(6, 1);
         for (int i = 0; i < n_norm; i++)
            send_req(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                     1'($urandom_range(1)));
      end
   endtask

   initial begin
      int rand_start;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 33;
      recv_stall_pct = 83;

      // zero span straight after reset
      send_req(KIND_NORMALIZE, 32'd1234, 1'b0, 1'b0);
      send_req(KIND_NORMALIZE, 32'd1234, 1'b1, 1'b0);
      // frame without any hit
      send_req(KIND_GATHER, 32'd99, 1'b1, 1'b1);
      send_req(KIND_NORMALIZE, 32'd5, 1'b0, 1'b0);
      // full depth range
      send_req(KIND_GATHER, 32'h0000_0000, 1'b0, 1'b0);
      send_req(KIND_GATHER, 32'hFFFF_FFFF, 1'b0, 1'b1);
      send_req(KIND_NORMALIZE, 32'h0000_0000, 1'b0, 1'b0);
      send_req(KIND_NORMALIZE, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_req(KIND_NORMALIZE, 32'h8000_0000, 1'b0, 1'b1);
      // small range with a skipped no-hit pixel
      send_req(KIND_GATHER, 32'd100, 1'b0, 1'b0);
      send_req(KIND_GATHER, 32'd5, 1'b1, 1'b0);
      send_req(KIND_GATHER, 32'd200, 1'b0, 1'b1);
      send_req(KIND_NORMALIZE, 32'd50, 1'b0, 1'b0);
      send_req(KIND_NORMALIZE, 32'd250, 1'b0, 1'b0);
      send_req(KIND_NORMALIZE, 32'd200, 1'b0, 1'b0);
      send_req(KIND_NORMALIZE, 32'd100, 1'b0, 1'b0);
      send_req(KIND_NORMALIZE, 32'd150, 1'b0, 1'b0);
      send_req(KIND_NORMALIZE, 32'd300, 1'b1, 1'b1);
      // single pixel frame gives a zero span
      send_req(KIND_GATHER, 32'd777, 1'b0, 1'b1);
      send_req(KIND_NORMALIZE, 32'd777, 1'b0, 1'b0);
      send_req(KIND_NORMALIZE, 32'd0, 1'b0, 1'b1);

      rand_start = sent_count;
      while (sent_count - rand_start < RANDOM_ITEMS) begin
         if (sent_count - rand_start < RANDOM_ITEMS / 3) begin
            send_idle_pct  = 33;
            recv_stall_pct = 83;
         end else if (sent_count - rand_start < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 83;
            recv_stall_pct = 33;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         run_random_frame();
         if ($urandom_range(99) < 10) wait_for_drain();
      end

      wait_for_drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
